### src/axis_angle_rotation_matrix_unit_assert.svh
// Assertion macros shared by the rotation matrix unit.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks that the consequent holds in the same cycle as the antecedent.
`define AARM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define AARM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AARM_ASSERT_IMP(label, ante, cons, msg)
`define AARM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/aarm_pkg.sv
// Types, constants and arithmetic helpers of the rotation matrix unit.
package aarm_pkg;

	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_STEPS = 16;

	localparam int WORK_FRAC   = 30;
	localparam int WW          = 34;
	localparam int ZW          = WW + 1;
	localparam int ANGLE_SHIFT = WORK_FRAC - 13;

	localparam int SQ_W      = 32;
	localparam int ROOT_W    = 31;
	localparam int SREM_W    = ROOT_W + 2;
	localparam int MAG_W     = 16;
	localparam int Q_W       = 31;
	localparam int DREM_W    = ROOT_W;
	localparam int DIV_SHIFT = WORK_FRAC + 15;
	localparam int DIV_DW    = MAG_W + DIV_SHIFT;
	localparam int CS_DELAY  = ROOT_W + Q_W - CORDIC_STEPS;
	localparam int OUT_SHIFT = WORK_FRAC - FRAC_BITS;

	localparam logic signed [WW-1:0] WORK_ONE = WW'(64'sd1 << WORK_FRAC);
	localparam logic signed [WW-1:0] GAIN_K   = WW'(64'sd652032874);
	localparam logic signed [ZW-1:0] PI_Z      = ZW'(64'sd3373259426);
	localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sd1686629713);
	localparam logic signed [15:0]   ANGLE_LIMIT = 16'sd25736;

	localparam logic signed [WW:0] OUT_ROUND =
		(OUT_SHIFT > 0) ? (WW+1)'(64'sd1 << (OUT_SHIFT - 1)) : '0;
	localparam logic signed [WW:0] OUT_LIM = (WW+1)'(64'sd1 << FRAC_BITS);
	localparam logic [15:0] OUT_ONE = 16'(64'sd1 << FRAC_BITS);

	typedef enum logic [1:0] {
		KIND_X    = 2'd0,
		KIND_Y    = 2'd1,
		KIND_Z    = 2'd2,
		KIND_AXIS = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] angle;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
		logic               zero_axis;
	} out_item_t;

	// Side information that rides along the square root pipeline.
	typedef struct packed {
		kind_t            kind;
		logic             zero_axis;
		logic [2:0]       neg;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic [MAG_W-1:0] mag_z;
	} sqrt_aux_t;

	// Side information that rides along the divider pipeline.
	typedef struct packed {
		kind_t      kind;
		logic       zero_axis;
		logic [2:0] neg;
	} div_aux_t;

	// Truncated arctangent of 2^-i in Q2.30.
	function automatic logic signed [WW-1:0] atan_entry(input int i);
		logic [31:0] e;
		unique case (i)
			0:  e = 32'h3243F6A8;
			1:  e = 32'h1DAC6705;
			2:  e = 32'h0FADBAFC;
			3:  e = 32'h07F56EA6;
			4:  e = 32'h03FEAB76;
			5:  e = 32'h01FFD55B;
			6:  e = 32'h00FFFAAA;
			7:  e = 32'h007FFF55;
			8:  e = 32'h003FFFEA;
			9:  e = 32'h001FFFFD;
			10: e = 32'h000FFFFF;
			11: e = 32'h0007FFFF;
			12: e = 32'h0003FFFF;
			13: e = 32'h0001FFFF;
			14: e = 32'h0000FFFF;
			15: e = 32'h00007FFF;
			16: e = 32'h00003FFF;
			17: e = 32'h00001FFF;
			18: e = 32'h00000FFF;
			19: e = 32'h000007FF;
			20: e = 32'h000003FF;
			21: e = 32'h000001FF;
			22: e = 32'h000000FF;
			23: e = 32'h0000007F;
			24: e = 32'h0000003F;
			25: e = 32'h0000001F;
			26: e = 32'h0000000F;
			27: e = 32'h00000007;
			28: e = 32'h00000003;
			29: e = 32'h00000001;
			default: e = 32'h00000000;
		endcase
		return WW'(e);
	endfunction

	// Q4.30 product with a floor shift back to Q4.30.
	function automatic logic signed [WW-1:0] mulw(input logic signed [WW-1:0] a,
		input logic signed [WW-1:0] b);
		logic signed [2*WW-1:0] p;
		p = a * b;
		return WW'(p >>> WORK_FRAC);
	endfunction

	// Rounds half up to the output format, saturates, keeps 16 bits.
	function automatic logic [15:0] to_out(input logic signed [WW-1:0] v);
		logic signed [WW:0] w;
		w = {v[WW-1], v};
		w = (w + OUT_ROUND) >>> OUT_SHIFT;
		if (w > OUT_LIM)
			w = OUT_LIM;
		if (w < -OUT_LIM)
			w = -OUT_LIM;
		return w[15:0];
	endfunction

endpackage

### src/aarm_cordic.sv
// Rotation-mode CORDIC pipeline, one micro-rotation per stage.
module aarm_cordic import aarm_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [WW-1:0] angle,
	input  logic                 fold,
	output logic signed [WW-1:0] cos_out,
	output logic signed [WW-1:0] sin_out
);

	logic signed [WW-1:0] x_s [CORDIC_STEPS];
	logic signed [WW-1:0] y_s [CORDIC_STEPS];
	logic signed [WW-1:0] z_s [CORDIC_STEPS];
	logic                 fold_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [WW-1:0] xp, yp, zp;
		logic                 fp;
		if (i == 0) begin : g_first
			assign xp = GAIN_K;
			assign yp = '0;
			assign zp = angle;
			assign fp = fold;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign fp = fold_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fold_s[i] <= fp;
				if (!zp[WW-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - atan_entry(i);
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + atan_entry(i);
				end
			end
		end
	end

	// A folded angle flips the sign of both results.
	assign cos_out = fold_s[CORDIC_STEPS-1] ? -x_s[CORDIC_STEPS-1] : x_s[CORDIC_STEPS-1];
	assign sin_out = fold_s[CORDIC_STEPS-1] ? -y_s[CORDIC_STEPS-1] : y_s[CORDIC_STEPS-1];

endmodule

### src/aarm_sqrt.sv
// Pipelined integer square root of the scaled axis length, one root bit per stage.
module aarm_sqrt import aarm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   sq,
	input  sqrt_aux_t         in_aux,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output sqrt_aux_t         out_aux
);

	logic                valid_s [ROOT_W];
	logic [SQ_W-1:0]     rad_s   [ROOT_W];
	logic [SREM_W-1:0]   rem_s   [ROOT_W];
	logic [ROOT_W-1:0]   root_s  [ROOT_W];
	sqrt_aux_t           aux_s   [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              valid_p;
		logic [SQ_W-1:0]   rad_p;
		logic [SREM_W-1:0] rem_p;
		logic [ROOT_W-1:0] root_p;
		sqrt_aux_t         aux_p;
		logic [SREM_W+1:0] cur, trial;
		logic              ge;

		if (k == 0) begin : g_first
			// The radicand is sq shifted up by 30, so the low pairs are zero.
			assign valid_p = in_valid;
			assign rad_p   = sq;
			assign rem_p   = '0;
			assign root_p  = '0;
			assign aux_p   = in_aux;
		end else begin : g_next
			assign valid_p = valid_s[k-1];
			assign rad_p   = rad_s[k-1];
			assign rem_p   = rem_s[k-1];
			assign root_p  = root_s[k-1];
			assign aux_p   = aux_s[k-1];
		end

		assign cur   = {rem_p, rad_p[SQ_W-1 -: 2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_p[SQ_W-3:0], 2'b00};
				rem_s[k]  <= ge ? SREM_W'(cur - trial) : SREM_W'(cur);
				root_s[k] <= {root_p[ROOT_W-2:0], ge};
				aux_s[k]  <= aux_p;
			end
		end
	end

	assign out_valid = valid_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_aux   = aux_s[ROOT_W-1];

endmodule

### src/aarm_div.sv
// Three-lane pipelined restoring divider that forms the unit axis, one quotient bit per stage.
module aarm_div import aarm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] divisor,
	input  sqrt_aux_t         in_aux,
	output logic              out_valid,
	output logic [Q_W-1:0]    quot [3],
	output div_aux_t          out_aux
);

	logic [MAG_W-1:0]  mag_in [3];
	div_aux_t          aux_in;

	logic              valid_s [Q_W];
	logic [ROOT_W-1:0] d_s     [Q_W];
	div_aux_t          aux_s   [Q_W];
	logic [DREM_W-1:0] rem_s   [Q_W][3];
	logic [Q_W-1:0]    low_s   [Q_W][3];
	logic [Q_W-1:0]    q_s     [Q_W][3];

	assign mag_in[0]        = in_aux.mag_x;
	assign mag_in[1]        = in_aux.mag_y;
	assign mag_in[2]        = in_aux.mag_z;
	assign aux_in.kind      = in_aux.kind;
	assign aux_in.zero_axis = in_aux.zero_axis;
	assign aux_in.neg       = in_aux.neg;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic              valid_p;
		logic [ROOT_W-1:0] d_p;
		div_aux_t          aux_p;

		if (k == 0) begin : g_first
			assign valid_p = in_valid;
			assign d_p     = divisor;
			assign aux_p   = aux_in;
		end else begin : g_next
			assign valid_p = valid_s[k-1];
			assign d_p     = d_s[k-1];
			assign aux_p   = aux_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k]   <= d_p;
				aux_s[k] <= aux_p;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DREM_W-1:0] rem_p;
			logic [Q_W-1:0]    low_p, q_p;
			logic [DREM_W:0]   cur, dext;
			logic              ge;

			if (k == 0) begin : g_first
				// Dividend is the magnitude shifted up by 45 plus half the divisor, so the quotient is in Q1.30.
				logic [DIV_DW-1:0] dividend;
				assign dividend = (DIV_DW'(mag_in[l]) << DIV_SHIFT) + DIV_DW'(divisor >> 1);
				assign rem_p    = DREM_W'(dividend >> Q_W);
				assign low_p    = dividend[Q_W-1:0];
				assign q_p      = '0;
			end else begin : g_next
				assign rem_p = rem_s[k-1][l];
				assign low_p = low_s[k-1][l];
				assign q_p   = q_s[k-1][l];
			end

			assign cur  = {rem_p, low_p[Q_W-1]};
			assign dext = {1'b0, d_p};
			assign ge   = (cur >= dext);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? DREM_W'(cur - dext) : DREM_W'(cur);
					low_s[k][l] <= {low_p[Q_W-2:0], 1'b0};
					q_s[k][l]   <= {q_p[Q_W-2:0], ge};
				end
			end
		end
	end

	assign out_valid = valid_s[Q_W-1];
	assign out_aux   = aux_s[Q_W-1];
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign quot[l] = q_s[Q_W-1][l];
	end

endmodule

### src/aarm_matrix.sv
// Matrix assembly: signed unit axis, products, entry selection and output rounding.
module aarm_matrix import aarm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [Q_W-1:0]       quot [3],
	input  div_aux_t             in_aux,
	input  logic signed [WW-1:0] cos_in,
	input  logic signed [WW-1:0] sin_in,
	output logic                 out_valid,
	output out_item_t            out_data
);

	logic                 valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	kind_t                kind_s2, kind_s3, kind_s4;
	logic                 zero_s2, zero_s3, zero_s4, zero_s5;

	logic signed [WW-1:0] u_s2 [3];
	logic signed [WW-1:0] t_s2, c_s2, s_s2;

	logic signed [WW-1:0] u_s3 [3];
	logic signed [WW-1:0] tu_s3 [3];
	logic signed [WW-1:0] su_s3 [3];
	logic signed [WW-1:0] c_s3, s_s3;

	logic signed [WW-1:0] txux_s4, txuy_s4, txuz_s4;
	logic signed [WW-1:0] tyux_s4, tyuy_s4, tyuz_s4;
	logic signed [WW-1:0] tzux_s4, tzuz_s4;
	logic signed [WW-1:0] su_s4 [3];
	logic signed [WW-1:0] c_s4, s_s4;

	logic signed [WW-1:0] m_n  [9];
	logic signed [WW-1:0] m_s5 [9];
	out_item_t            out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Stage 2: apply the axis signs and form 1 - cos.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				u_s2[l] <= in_aux.neg[l] ? -WW'(quot[l]) : WW'(quot[l]);
			end
			t_s2    <= WORK_ONE - cos_in;
			c_s2    <= cos_in;
			s_s2    <= sin_in;
			kind_s2 <= in_aux.kind;
			zero_s2 <= in_aux.zero_axis;
		end
	end

	// Stage 3: first products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				tu_s3[l] <= mulw(t_s2, u_s2[l]);
				su_s3[l] <= mulw(s_s2, u_s2[l]);
				u_s3[l]  <= u_s2[l];
			end
			c_s3    <= c_s2;
			s_s3    <= s_s2;
			kind_s3 <= kind_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Stage 4: the outer product terms of the general formula.
	always_ff @(posedge clk) begin
		if (en) begin
			txux_s4 <= mulw(tu_s3[0], u_s3[0]);
			txuy_s4 <= mulw(tu_s3[0], u_s3[1]);
			txuz_s4 <= mulw(tu_s3[0], u_s3[2]);
			tyux_s4 <= mulw(tu_s3[1], u_s3[0]);
			tyuy_s4 <= mulw(tu_s3[1], u_s3[1]);
			tyuz_s4 <= mulw(tu_s3[1], u_s3[2]);
			tzux_s4 <= mulw(tu_s3[2], u_s3[0]);
			tzuz_s4 <= mulw(tu_s3[2], u_s3[2]);
			su_s4   <= su_s3;
			c_s4    <= c_s3;
			s_s4    <= s_s3;
			kind_s4 <= kind_s3;
			zero_s4 <= zero_s3;
		end
	end

	// Stage 5: pick the entries. Single-axis kinds use the transposed signs.
	// Entry (2,1) reuses the y-z term, as the general formula here defines it.
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			m_n[k] = (k % 4 == 0) ? WORK_ONE : '0;
		end
		unique case (kind_s4)
			KIND_X: begin
				m_n[4] = c_s4;
				m_n[5] = s_s4;
				m_n[7] = -s_s4;
				m_n[8] = c_s4;
			end
			KIND_Y: begin
				m_n[0] = c_s4;
				m_n[2] = -s_s4;
				m_n[6] = s_s4;
				m_n[8] = c_s4;
			end
			KIND_Z: begin
				m_n[0] = c_s4;
				m_n[1] = s_s4;
				m_n[3] = -s_s4;
				m_n[4] = c_s4;
			end
			KIND_AXIS: begin
				if (!zero_s4) begin
					m_n[0] = c_s4 + txux_s4;
					m_n[1] = txuy_s4 - su_s4[2];
					m_n[2] = txuz_s4 + su_s4[1];
					m_n[3] = tyux_s4 + su_s4[2];
					m_n[4] = c_s4 + tyuy_s4;
					m_n[5] = tyuz_s4 - su_s4[0];
					m_n[6] = tzux_s4 - su_s4[1];
					m_n[7] = tyuz_s4 + su_s4[0];
					m_n[8] = c_s4 + tzuz_s4;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s5    <= m_n;
			zero_s5 <= zero_s4;
		end
	end

	// Stage 6: round and saturate each entry.
	always_ff @(posedge clk) begin
		if (en) begin
			out_s6.r00       <= to_out(m_s5[0]);
			out_s6.r01       <= to_out(m_s5[1]);
			out_s6.r02       <= to_out(m_s5[2]);
			out_s6.r10       <= to_out(m_s5[3]);
			out_s6.r11       <= to_out(m_s5[4]);
			out_s6.r12       <= to_out(m_s5[5]);
			out_s6.r20       <= to_out(m_s5[6]);
			out_s6.r21       <= to_out(m_s5[7]);
			out_s6.r22       <= to_out(m_s5[8]);
			out_s6.zero_axis <= zero_s5;
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = out_s6;

endmodule

### src/axis_angle_rotation_matrix_unit.sv
// Throughput: one transfer per cycle while the skid register is empty;
// the 31-stage square root and 31-stage divider set depth.
// A result that waits at the output parks one more result in a skid register.
// Reset (arst_n low) clears every valid bit, including those of the output and skid registers, at once.
// No clearing pass is needed; in_ready is high from the first cycle after reset.
`include "axis_angle_rotation_matrix_unit_assert.svh"
module axis_angle_rotation_matrix_unit import aarm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	// The whole pipeline advances together while the skid register is empty.
	// The skid register only fills when the output register holds a result
	// that is not taken, so in_ready comes straight from a flip-flop.
	logic en;

	// Input stage: clamp and fold the angle, square the axis.
	logic signed [15:0]     ang_c;
	logic signed [ZW-1:0]   ang_w;
	logic signed [WW-1:0]   z_n;
	logic                   fold_n;
	logic [MAG_W-1:0]       mag_x, mag_y, mag_z;
	sqrt_aux_t              aux_n;

	logic                   valid_s1;
	logic signed [WW-1:0]   z_s1;
	logic                   fold_s1;
	logic [SQ_W-1:0]        sq_s1;
	sqrt_aux_t              aux_s1;

	// Square root and divider stages.
	logic                   root_valid;
	logic [ROOT_W-1:0]      root;
	sqrt_aux_t              root_aux;
	logic                   div_valid;
	logic [Q_W-1:0]         quot [3];
	div_aux_t               div_aux;

	// Sine and cosine, held back until the unit axis is ready.
	logic signed [WW-1:0]   cos_w, sin_w;
	logic signed [WW-1:0]   c_dl_s [CS_DELAY];
	logic signed [WW-1:0]   s_dl_s [CS_DELAY];

	// Last pipeline stage, output register and skid register.
	logic                   pipe_valid;
	out_item_t              pipe_data;
	logic                   out_valid_q, skid_valid_q;
	out_item_t              out_data_q, skid_data_q;
	logic                   out_free;
	logic                   skid_load;

	assign en       = !skid_valid_q;
	assign in_ready = en;

	always_comb begin
		ang_c = in_data.angle;
		if (ang_c > ANGLE_LIMIT)
			ang_c = ANGLE_LIMIT;
		if (ang_c < -ANGLE_LIMIT)
			ang_c = -ANGLE_LIMIT;
		ang_w = ZW'(ang_c) <<< ANGLE_SHIFT;

		// Angles beyond a quarter turn are brought back by half a turn;
		// the CORDIC then negates both results.
		fold_n = 1'b0;
		z_n    = WW'(ang_w);
		if (ang_w > HALF_PI_Z) begin
			z_n    = WW'(ang_w - PI_Z);
			fold_n = 1'b1;
		end else if (ang_w < -HALF_PI_Z) begin
			z_n    = WW'(ang_w + PI_Z);
			fold_n = 1'b1;
		end

		mag_x = in_data.axis_x[15] ? MAG_W'(-in_data.axis_x) : MAG_W'(in_data.axis_x);
		mag_y = in_data.axis_y[15] ? MAG_W'(-in_data.axis_y) : MAG_W'(in_data.axis_y);
		mag_z = in_data.axis_z[15] ? MAG_W'(-in_data.axis_z) : MAG_W'(in_data.axis_z);

		aux_n.kind      = in_data.kind;
		aux_n.zero_axis = (in_data.kind == KIND_AXIS) && (mag_x == '0) && (mag_y == '0)
			&& (mag_z == '0);
		aux_n.neg       = {in_data.axis_z[15], in_data.axis_y[15], in_data.axis_x[15]};
		aux_n.mag_x     = mag_x;
		aux_n.mag_y     = mag_y;
		aux_n.mag_z     = mag_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= z_n;
			fold_s1 <= fold_n;
			sq_s1   <= SQ_W'(mag_x) * SQ_W'(mag_x) + SQ_W'(mag_y) * SQ_W'(mag_y)
				+ SQ_W'(mag_z) * SQ_W'(mag_z);
			aux_s1  <= aux_n;
		end
	end

	aarm_cordic u_cordic (
		.clk     (clk),
		.en      (en),
		.angle   (z_s1),
		.fold    (fold_s1),
		.cos_out (cos_w),
		.sin_out (sin_w)
	);

	aarm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.sq        (sq_s1),
		.in_aux    (aux_s1),
		.out_valid (root_valid),
		.root      (root),
		.out_aux   (root_aux)
	);

	aarm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.divisor   (root),
		.in_aux    (root_aux),
		.out_valid (div_valid),
		.quot      (quot),
		.out_aux   (div_aux)
	);

	// Sine and cosine finish well before the divider; this delay line lines them up.
	always_ff @(posedge clk) begin
		if (en) begin
			c_dl_s[0] <= cos_w;
			s_dl_s[0] <= sin_w;
			for (int i = 1; i < CS_DELAY; i++) begin
				c_dl_s[i] <= c_dl_s[i-1];
				s_dl_s[i] <= s_dl_s[i-1];
			end
		end
	end

	aarm_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.quot      (quot),
		.in_aux    (div_aux),
		.cos_in    (c_dl_s[CS_DELAY-1]),
		.sin_in    (s_dl_s[CS_DELAY-1]),
		.out_valid (pipe_valid),
		.out_data  (pipe_data)
	);

	// The output register is free when empty or when its result is taken this cycle.
	// A result leaving the pipeline while the output is held goes to the skid register,
	// which then stops the pipeline until it has moved to the output.
	assign out_free  = !out_valid_q || out_ready;
	assign skid_load = !out_free && pipe_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || pipe_valid;
				skid_valid_q <= 1'b0;
			end else if (skid_load) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : pipe_data;
		end
		if (skid_load) begin
			skid_data_q <= pipe_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`AARM_ASSERT_IMP(a_skid_behind_output, skid_valid_q, out_valid_q, "skid holds a result while the output register is empty")
	`AARM_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready, !skid_valid_q, "skid register did not drain after an output transfer")
	`AARM_ASSERT_IMP(a_zero_axis_identity, out_valid_q && out_data_q.zero_axis, out_data_q.r00 == OUT_ONE && out_data_q.r11 == OUT_ONE && out_data_q.r22 == OUT_ONE && out_data_q.r01 == '0 && out_data_q.r12 == '0 && out_data_q.r20 == '0, "zero axis result is not the identity")

endmodule

### tb/axis_angle_rotation_matrix_unit_tb.sv
// Self-checking testbench for the axis-angle rotation matrix unit.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_unit_tb;
	import aarm_pkg::*;

	// The run is cut off here, far beyond the slowest legal run.
	localparam int CYCLE_LIMIT = 300000;
	// Cycles of quiet after the last result, more than the pipeline depth.
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_PER_PHASE = 158;

	// Q2.30 constants of the sine/cosine engine.
	localparam longint Q30_ONE = 64'sd1 << 30;
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint MAX_ANGLE = 64'sd25736;

	// Truncated arctangent of 2^-i in Q2.30, for the steps the engine runs.
	localparam longint ARCTAN_Q30 [16] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
	};

	// One row of the directed stimulus. Where typed is set, the expected
	// matrix is written by hand instead of being predicted.
	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t matrix;
	} directed_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	// Matrices still owed by the block, oldest first.
	out_item_t pending_matrices [$];
	directed_row_t directed_rows [$];
	int error_count;
	int cycle_count;
	// Percentages of cycles in which the sender idles and the receiver stalls.
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	axis_angle_rotation_matrix_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Product of two Q2.30 values, floored back to Q2.30.
	function automatic longint q30_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return p >>> 30;
	endfunction

	// Rounds a Q2.30 entry half up to Q1.14 and saturates it to plus or minus one.
	function automatic logic [15:0] q30_to_entry(input longint v);
		longint w;
		w = (v + (64'sd1 << 15)) >>> 16;
		if (w > 64'sd16384)
			w = 64'sd16384;
		if (w < -64'sd16384)
			w = -64'sd16384;
		return w[15:0];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// One axis component scaled to unit length in Q2.30, rounded to nearest.
	function automatic longint unit_component(input longint a, input longint unsigned r);
		longint unsigned mag;
		longint unsigned q;
		mag = (a < 0) ? longint'(-a) : longint'(a);
		q = ((mag << 45) + (r >> 1)) / r;
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Computes the rotation matrix that the block must return for one request.
	function automatic out_item_t rotation_matrix(input in_item_t req);
		longint ang, x, y, z, dx, dy, c, s;
		longint ax, ay, az, ux, uy, uz, t, tx, ty, tz;
		longint m [9];
		longint unsigned root;
		bit folded;
		out_item_t res;
		ang = longint'(req.angle);
		if (ang > MAX_ANGLE)
			ang = MAX_ANGLE;
		if (ang < -MAX_ANGLE)
			ang = -MAX_ANGLE;
		// Fold the angle into plus or minus pi/2 and flip the signs afterwards.
		z = ang <<< 17;
		folded = 1'b0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			folded = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			folded = 1'b1;
		end
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN_Q30[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN_Q30[i];
			end
		end
		c = folded ? -x : x;
		s = folded ? -y : y;
		for (int k = 0; k < 9; k++)
			m[k] = (k % 4 == 0) ? Q30_ONE : 0;
		res.zero_axis = 1'b0;
		ax = longint'(req.axis_x);
		ay = longint'(req.axis_y);
		az = longint'(req.axis_z);
		// The single-axis kinds keep the transposed sign convention.
		case (req.kind)
			KIND_X: begin
				m[4] = c; m[5] = s; m[7] = -s; m[8] = c;
			end
			KIND_Y: begin
				m[0] = c; m[2] = -s; m[6] = s; m[8] = c;
			end
			KIND_Z: begin
				m[0] = c; m[1] = s; m[3] = -s; m[4] = c;
			end
			default: begin
				if (ax == 0 && ay == 0 && az == 0) begin
					res.zero_axis = 1'b1;
				end else begin
					root = int_sqrt(longint'(ax * ax + ay * ay + az * az) << 30);
					ux = unit_component(ax, root);
					uy = unit_component(ay, root);
					uz = unit_component(az, root);
					t = Q30_ONE - c;
					tx = q30_mul(t, ux);
					ty = q30_mul(t, uy);
					tz = q30_mul(t, uz);
					m[0] = c + q30_mul(tx, ux);
					m[1] = q30_mul(tx, uy) - q30_mul(s, uz);
					m[2] = q30_mul(tx, uz) + q30_mul(s, uy);
					m[3] = q30_mul(ty, ux) + q30_mul(s, uz);
					m[4] = c + q30_mul(ty, uy);
					m[5] = q30_mul(ty, uz) - q30_mul(s, ux);
					m[6] = q30_mul(tz, ux) - q30_mul(s, uy);
					// This entry uses ty, not tz, as the block does.
					m[7] = q30_mul(ty, uz) + q30_mul(s, ux);
					m[8] = c + q30_mul(tz, uz);
				end
			end
		endcase
		res.r00 = q30_to_entry(m[0]);
		res.r01 = q30_to_entry(m[1]);
		res.r02 = q30_to_entry(m[2]);
		res.r10 = q30_to_entry(m[3]);
		res.r11 = q30_to_entry(m[4]);
		res.r12 = q30_to_entry(m[5]);
		res.r20 = q30_to_entry(m[6]);
		res.r21 = q30_to_entry(m[7]);
		res.r22 = q30_to_entry(m[8]);
		return res;
	endfunction

	task automatic add_row(input kind_t kind, input logic signed [15:0] ang,
		input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z, input bit typed);
		directed_row_t row;
		row.req = '{kind: kind, angle: ang, axis_x: x, axis_y: y, axis_z: z};
		row.typed = typed;
		// The only hand-written matrix is the identity with the zero-axis flag.
		row.matrix = '{r00: 16'sd16384, r11: 16'sd16384, r22: 16'sd16384,
			zero_axis: 1'b1, default: '0};
		directed_rows.push_back(row);
	endtask

	// Offers one request, idling first as the phase asks, and records the
	// expected matrix at the edge where the transfer takes place.
	task automatic send_request(input in_item_t req, input out_item_t matrix);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do
			@(posedge clk);
		while (!in_ready);
		pending_matrices.push_back(matrix);
	endtask

	function automatic logic signed [15:0] random_angle();
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'sd25736 : -16'sd25736;
			2: return 16'(12868 + 8 - $urandom_range(16));
			3: return 16'(-12868 + 8 - $urandom_range(16));
			default: return 16'($urandom_range(51472) - 25736);
		endcase
	endfunction

	function automatic logic signed [15:0] random_axis_component();
		case ($urandom_range(5))
			0: return '0;
			1: return 16'($urandom_range(6) - 3);
			2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_request();
		in_item_t req;
		req.kind = kind_t'($urandom_range(3));
		// The general axis is the only kind that uses the divider result, so it gets extra weight.
		if ($urandom_range(1))
			req.kind = KIND_AXIS;
		req.angle = random_angle();
		req.axis_x = random_axis_component();
		req.axis_y = random_axis_component();
		req.axis_z = random_axis_component();
		if ($urandom_range(19) == 0) begin
			req.axis_x = '0;
			req.axis_y = '0;
			req.axis_z = '0;
		end
		return req;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			error_count++;
		end
	endtask

	// The receiver stalls at random and checks every matrix that it takes.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_matrices.size() == 0) begin
					$error("matrix transfer with no request outstanding");
					error_count++;
				end else begin
					want = pending_matrices.pop_front();
					check_field("r00", want.r00, out_data.r00);
					check_field("r01", want.r01, out_data.r01);
					check_field("r02", want.r02, out_data.r02);
					check_field("r10", want.r10, out_data.r10);
					check_field("r11", want.r11, out_data.r11);
					check_field("r12", want.r12, out_data.r12);
					check_field("r20", want.r20, out_data.r20);
					check_field("r21", want.r21, out_data.r21);
					check_field("r22", want.r22, out_data.r22);
					check_field("zero_axis", 16'(want.zero_axis), 16'(out_data.zero_axis));
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		in_item_t req;
		error_count = 0;
		cycle_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;

		// Directed part: every kind, the angle extremes and the clamp, pi/2 fold
		// boundaries, the zero axis on every kind, and extreme axis components.
		add_row(KIND_X, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_row(KIND_Y, 16'sd25736, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_row(KIND_Z, -16'sd25736, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_row(KIND_X, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd1, 1'b0);
		add_row(KIND_Y, 16'sh8000, 16'sh7FFF, 16'sh8000, -16'sd1, 1'b0);
		add_row(KIND_Z, 16'sd12868, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_row(KIND_Z, 16'sd12869, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_row(KIND_X, -16'sd12869, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_row(KIND_AXIS, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
		add_row(KIND_AXIS, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 1'b1);
		add_row(KIND_AXIS, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1);
		add_row(KIND_AXIS, 16'sd6434, 16'sd1, 16'sd0, 16'sd0, 1'b0);
		add_row(KIND_AXIS, 16'sd6434, 16'sd0, -16'sd1, 16'sd0, 1'b0);
		add_row(KIND_AXIS, 16'sd6434, 16'sd0, 16'sd0, 16'sd5, 1'b0);
		add_row(KIND_AXIS, 16'sd25736, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		add_row(KIND_AXIS, -16'sd25736, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
		add_row(KIND_AXIS, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
		add_row(KIND_AXIS, 16'sh8000, 16'sd1, 16'sd1, 16'sd1, 1'b0);
		add_row(KIND_AXIS, 16'sd12868, 16'sd3, 16'sd4, 16'sd0, 1'b0);
		add_row(KIND_AXIS, -16'sd12868, -16'sd3, 16'sd0, 16'sd4, 1'b0);
		add_row(KIND_AXIS, 16'sd1, 16'sh8000, 16'sd0, 16'sd0, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No idling while the directed rows go through.
		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed ?
				directed_rows[i].matrix : rotation_matrix(directed_rows[i].req));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 74; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 74; end
				default: begin
					// Hold off until the pipeline has emptied completely.
					in_valid <= 1'b0;
					while (pending_matrices.size() != 0)
						@(posedge clk);
					sender_idle_pct = 20;
					receiver_stall_pct = 20;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				req = random_request();
				send_request(req, rotation_matrix(req));
			end
		end
		in_valid <= 1'b0;

		while (pending_matrices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### axis_angle_rotation_matrix_unit.f
+incdir+src
src/aarm_pkg.sv
src/aarm_cordic.sv
src/aarm_sqrt.sv
src/aarm_div.sv
src/aarm_matrix.sv
src/axis_angle_rotation_matrix_unit.sv
tb/axis_angle_rotation_matrix_unit_tb.sv
